// File: src/sfr_pkg.sv
`default_nettype none
package sfr_pkg;

	localparam int MAX_PATTERN_DEF = 8;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 4;
	localparam int STR_W = 64;
	localparam int RES_MAX = 8;
	localparam int RIDX_W = 3;
	localparam int RCNT_W = 4;
	localparam int CFG_IDX_W = 2;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_LEN  = 2'd0,
		CFG_TARGET_STR  = 2'd1,
		CFG_REPL_LEN    = 2'd2,
		CFG_REPL_STR    = 2'd3
	} cfg_idx_t;

	// lengths already clamped
	typedef struct packed {
		logic [LEN_W-1:0] target_length;
		logic [STR_W-1:0] target_bytes;
		logic [LEN_W-1:0] replacement_length;
		logic [STR_W-1:0] replacement_bytes;
	} cfg_t;

	typedef struct packed {
		logic [RES_MAX-1:0][BYTE_W-1:0] bytes;
		logic [RCNT_W-1:0]              count;
		logic                           marker;
		logic                           eot;
	} result_t;

	function automatic byte_t pick_byte(input logic [STR_W-1:0] w, input logic [RIDX_W-1:0] j);
		return w[{j, 3'b000} +: BYTE_W];
	endfunction

endpackage
`default_nettype wire

// File: src/sfr_cfg_regs.sv
`default_nettype none
module sfr_cfg_regs #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sfr_pkg::STR_W-1:0]     cfg_data,
	output sfr_pkg::cfg_t                      cfg
);
	import sfr_pkg::*;

	logic [LEN_W-1:0] tlen_q;
	logic [STR_W-1:0] tstr_q;
	logic [LEN_W-1:0] rlen_q;
	logic [STR_W-1:0] rstr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= '0;
			tstr_q <= '0;
			rlen_q <= '0;
			rstr_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TARGET_LEN: tlen_q <= cfg_data[LEN_W-1:0];
				CFG_TARGET_STR: tstr_q <= cfg_data;
				CFG_REPL_LEN:   rlen_q <= cfg_data[LEN_W-1:0];
				CFG_REPL_STR:   rstr_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_comb begin
		cfg.target_length = (int'(tlen_q) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : tlen_q;
		cfg.target_bytes = tstr_q;
		cfg.replacement_length = (int'(rlen_q) > RES_MAX) ? LEN_W'(RES_MAX) : rlen_q;
		cfg.replacement_bytes = rstr_q;
	end

endmodule
`default_nettype wire

// File: src/sfr_window.sv
`default_nettype none
module sfr_window #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sfr_pkg::byte_t  in_byte,
	input  wire logic            in_eot,
	input  wire sfr_pkg::cfg_t   cfg,
	input  wire logic            commit,
	output sfr_pkg::result_t     res
);
	import sfr_pkg::*;

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int VW = MAX_PATTERN * BYTE_W;

	logic [VW-1:0]          win_q;
	logic [CW-1:0]          cnt_q;
	logic [VW-1:0]          buf_v;
	logic [VW-1:0]          shifted;
	logic [CW-1:0]          n;
	logic [CW-1:0]          k;
	logic [MAX_PATTERN-1:0] ok;
	logic                   match;

	assign n = cnt_q + CW'(1);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			buf_v[i*BYTE_W +: BYTE_W] = (i < int'(cnt_q)) ? win_q[i*BYTE_W +: BYTE_W] : in_byte;
		end
	end

	// tail starting at i must be a prefix of the target
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			ok[i] = (i < int'(n));
			if (i == 0) begin
				ok[i] = ok[i] && (int'(n) <= int'(cfg.target_length));
			end else begin
				ok[i] = ok[i] && ((int'(n) - i) < int'(cfg.target_length));
			end
			for (int p = 0; p < MAX_PATTERN; p++) begin
				if (p >= i && p < int'(n) &&
				    buf_v[p*BYTE_W +: BYTE_W] != pick_byte(cfg.target_bytes, RIDX_W'(p - i))) begin
					ok[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		k = n;
		for (int i = MAX_PATTERN - 1; i >= 0; i--) begin
			if (ok[i]) begin
				k = CW'(i);
			end
		end
	end

	assign match = (k == '0) && (LEN_W'(n) == cfg.target_length);
	assign shifted = buf_v >> {k, 3'b000};

	always_comb begin
		res.eot = in_eot;
		res.marker = 1'b0;
		if (match) begin
			res.bytes = cfg.replacement_bytes;
			res.count = RCNT_W'(cfg.replacement_length);
		end else begin
			res.bytes = (RES_MAX*BYTE_W)'(buf_v);
			res.count = in_eot ? RCNT_W'(n) : RCNT_W'(k);
		end
		if (in_eot && res.count == '0) begin
			res.bytes = '0;
			res.count = RCNT_W'(1);
			res.marker = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (commit) begin
			cnt_q <= (match || in_eot) ? '0 : (n - k);
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			win_q <= shifted;
		end
	end

endmodule
`default_nettype wire

// File: src/sfr_emit.sv
`default_nettype none
module sfr_emit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire sfr_pkg::result_t           res_in,
	output logic                            free,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [sfr_pkg::BYTE_W-1:0]      m_tdata,
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);
	import sfr_pkg::*;

	logic [RES_MAX-1:0][BYTE_W-1:0] bytes_q;
	logic [RCNT_W-1:0]              count_q;
	logic [RIDX_W-1:0]              idx_q;
	logic                           marker_q;
	logic                           eot_q;
	logic                           valid_q;
	logic                           last;

	assign last = (RCNT_W'(idx_q) + RCNT_W'(1)) == count_q;
	assign free = !valid_q || (m_tready && last);

	assign m_tvalid = valid_q;
	assign m_tdata = bytes_q[idx_q];
	assign m_tuser = {eot_q && last, !marker_q};
	assign m_tlast = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (valid_q && m_tready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + RIDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res_in.bytes;
			count_q <= res_in.count;
			marker_q <= res_in.marker;
			eot_q <= res_in.eot;
		end
	end

endmodule
`default_nettype wire

// File: src/stream_find_replace.sv
// stream_find_replace: replaces every leftmost, non-overlapping occurrence of
// a configured target string in a byte stream by a replacement string.
// input stream s_*: one text byte per word, s_tlast marks the final byte.
// output stream m_*: one edited byte per word; m_tuser[0] is low only on the
// empty end marker, m_tuser[1] flags the final word of the text, m_tlast the
// final word caused by one input word.
// cfg_*: register writes (0 target length, 1 target bytes, 2 replacement
// length, 3 replacement bytes); write only while the stream is idle.
// path: a taken input word waits in the input register, then its results are
// loaded into the result register, from which the output is driven.
// throughput: one input word per cycle while each gives at most one result
// and m_tready is high; a word giving several results holds the result
// register until all are sent, one byte per cycle that m_tready is high.
// reset empties the window and clears config and valid state: pass-through.
// when m_tready is low the result word holds, the input register fills and
// s_tready drops; words that give no result still pass while the output waits.
`default_nettype none
module stream_find_replace #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [sfr_pkg::BYTE_W-1:0]    s_tdata,   // text_byte
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [sfr_pkg::BYTE_W-1:0]         m_tdata,   // out_byte
	output logic [1:0]                         m_tuser,   // has_byte, text_done
	output logic                               m_tlast,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sfr_pkg::STR_W-1:0]     cfg_data
);
	import sfr_pkg::*;

	cfg_t    cfg;
	result_t res;
	byte_t   byte_s1;
	logic    eot_s1;
	logic    valid_s1;
	logic    free;
	logic    advance;

	sfr_cfg_regs #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfr_window #(.MAX_PATTERN(MAX_PATTERN)) u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (byte_s1),
		.in_eot  (eot_s1),
		.cfg     (cfg),
		.commit  (advance),
		.res     (res)
	);

	sfr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res.count != '0),
		.res_in   (res),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assign advance = valid_s1 && (res.count == '0 || free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eot_s1 <= s_tlast;
		end
	end

endmodule
`default_nettype wire

// File: dv/stream_find_replace_tb.sv
`timescale 1ns / 1ps
module stream_find_replace_tb;
	import sfr_pkg::*;

	localparam int WIN = MAX_PATTERN_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 3000;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              has_byte;
		logic              run_end;
		logic              text_done;
	} edit_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;   // text_byte
	logic              s_tlast = 1'b0; // end_of_text
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [BYTE_W-1:0] m_tdata;        // out_byte
	logic [1:0]        m_tuser;        // has_byte, text_done
	logic              m_tlast;        // run_end
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	cfg_idx_t          cfg_index = CFG_TARGET_LEN;
	logic [STR_W-1:0]  cfg_data = '0;

	// predictor copy of the registers and the window
	logic [LEN_W-1:0] tgt_len = '0;
	logic [STR_W-1:0] tgt_str = '0;
	logic [LEN_W-1:0] repl_len = '0;
	logic [STR_W-1:0] repl_str = '0;
	byte_t            held_bytes [WIN];
	int               held_count = 0;

	edit_word_t expected_words [$];
	edit_word_t step_words [$];

	int error_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cfg_writes = 0;
	int settings_applied = 0;
	int stuck_cycles = 0;

	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold_requests = 0;
	int rx_hold_served = 0;
	int rx_hold_left = 0;

	stream_find_replace DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch on %s at edited word %0d: got %h, expected %h",
			what, words_checked, got, want);
		error_count++;
	endtask

	function automatic void add_word(input byte_t b, input bit has);
		edit_word_t w;
		if (step_words.size() < RES_MAX) begin
			w.out_byte = has ? b : '0;
			w.has_byte = has;
			w.run_end = 1'b0;
			w.text_done = 1'b0;
			step_words.push_back(w);
		end
	endfunction

	function automatic void predict_edit(input byte_t text_byte, input logic end_of_text);
		byte_t      seq [WIN+1];
		int         held, total, keep_at, tail, eff_len, eff_repl, i, j;
		bit         fits;
		edit_word_t w;
		step_words.delete();
		held = (held_count > WIN - 1) ? WIN - 1 : held_count;
		for (i = 0; i < held; i++)
			seq[i] = held_bytes[i];
		seq[held] = text_byte;
		total = held + 1;
		eff_len = (tgt_len > WIN) ? WIN : tgt_len;
		eff_repl = (repl_len > 8) ? 8 : repl_len;
		// first position whose tail can still start (or complete) the target
		keep_at = total;
		for (i = 0; i < total && keep_at == total; i++) begin
			tail = total - i;
			fits = (i == 0) ? (tail <= eff_len) : (tail < eff_len);
			for (j = 0; fits && j < tail; j++)
				if (seq[i+j] != tgt_str[8*j +: 8])
					fits = 1'b0;
			if (fits)
				keep_at = i;
		end
		for (i = 0; i < keep_at; i++)
			add_word(seq[i], 1'b1);
		tail = total - keep_at;
		if (keep_at == 0 && tail == eff_len) begin
			for (j = 0; j < eff_repl; j++)
				add_word(repl_str[8*j +: 8], 1'b1);
			held_count = 0;
		end else begin
			for (j = 0; j < tail; j++)
				held_bytes[j] = seq[keep_at+j];
			held_count = tail;
		end
		if (end_of_text) begin
			for (j = 0; j < held_count; j++)
				add_word(held_bytes[j], 1'b1);
			held_count = 0;
			if (step_words.size() == 0)
				add_word('0, 1'b0);
		end
		if (step_words.size() != 0) begin
			w = step_words.pop_back();
			w.run_end = 1'b1;
			w.text_done = end_of_text;
			step_words.push_back(w);
		end
		foreach (step_words[p])
			expected_words.push_back(step_words[p]);
	endfunction

	task automatic send_word(input byte_t b, input logic eot);
		if (!tx_quiet && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
		predict_edit(b, eot);
	endtask

	task automatic send_text(input string s, input bit eot);
		int i;
		for (i = 0; i < s.len(); i++)
			send_word(s[i], eot && (i == s.len() - 1));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input cfg_idx_t idx, input logic [STR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_TARGET_LEN: tgt_len = value[LEN_W-1:0];
			CFG_TARGET_STR: tgt_str = value;
			CFG_REPL_LEN:   repl_len = value[LEN_W-1:0];
			CFG_REPL_STR:   repl_str = value;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic apply_config(input logic [LEN_W-1:0] tl, input logic [STR_W-1:0] ts,
			input logic [LEN_W-1:0] rl, input logic [STR_W-1:0] rs);
		wait_drained();
		program_reg(CFG_TARGET_LEN, STR_W'(tl));
		program_reg(CFG_TARGET_STR, ts);
		program_reg(CFG_REPL_LEN, STR_W'(rl));
		program_reg(CFG_REPL_STR, rs);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	task automatic test_passthrough_after_reset();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
	endtask

	task automatic test_replace();
		apply_config(4'd2, 64'h6261, 4'd3, 64'h5A5958);
		send_text("aab", 1'b1);
	endtask

	task automatic test_delete_end_marker();
		apply_config(4'd2, 64'h6261, 4'd0, 64'h0);
		send_text("ab", 1'b1);
	endtask

	task automatic test_full_length_strings();
		int i;
		apply_config(4'd8, 64'hFF00_A55A_3CC3_0FF0, 4'd8, 64'h8877_6655_4433_2211);
		for (i = 0; i < WIN; i++)
			send_word(tgt_str[8*i +: 8], i == WIN - 1);
	endtask

	task automatic test_oversized_lengths();
		int i;
		apply_config(4'd15, 64'h0706_0504_0302_0100, 4'd12, 64'hF0E1_D2C3_B4A5_9687);
		for (i = 0; i < WIN; i++)
			send_word(tgt_str[8*i +: 8], i == WIN - 1);
	endtask

	task automatic test_target_change_mid_text();
		apply_config(4'd2, 64'h6261, 4'd1, 64'h21);
		send_text("a", 1'b0);
		// held byte stays and is judged against the new target
		wait_drained();
		program_reg(CFG_TARGET_LEN, 64'd3);
		program_reg(CFG_TARGET_STR, 64'h797861);
		cfg_valid <= 1'b0;
		@(posedge clk);
		settings_applied++;
		send_text("xz", 1'b1);
	endtask

	task automatic test_output_backpressure();
		int i;
		apply_config(4'd1, 64'h5A, 4'd8, {$urandom, $urandom});
		rx_hold_requests++;
		for (i = 0; i < 40; i++)
			send_word(($urandom_range(99) < 70) ? 8'h5A : byte_t'($urandom_range(0, 255)),
				i == 39);
		wait_drained();
	endtask

	task automatic test_back_to_back();
		byte_t alpha [3];
		int    i;
		foreach (alpha[a])
			alpha[a] = byte_t'($urandom_range(0, 255));
		apply_config(4'd3, {40'h0, alpha[2], alpha[1], alpha[0]}, 4'd1, {$urandom, $urandom});
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		for (i = 0; i < 40; i++)
			send_word(alpha[$urandom_range(0, 2)], i == 39);
		wait_drained();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_random_texts();
		byte_t            alpha [3];
		byte_t            text [$];
		logic [STR_W-1:0] tstr;
		int               tlen, eff, phase_words, total, n, r, k, cut;
		total = 0;
		while (total < 170) begin
			foreach (alpha[a])
				alpha[a] = byte_t'($urandom_range(0, 255));
			tstr = '0;
			for (k = 0; k < WIN; k++)
				tstr[8*k +: 8] = alpha[$urandom_range(0, 2)];
			tlen = $urandom_range(0, 9);
			if (tlen == 9)
				tlen = $urandom_range(9, 15);
			eff = (tlen > WIN) ? WIN : tlen;
			apply_config(tlen[LEN_W-1:0], tstr, LEN_W'($urandom_range(0, 15)),
				{$urandom, $urandom});
			phase_words = 0;
			while (phase_words < 30) begin
				text.delete();
				n = $urandom_range(1, 12);
				while (text.size() < n) begin
					r = $urandom_range(99);
					if (eff > 0 && r < 30) begin
						for (k = 0; k < eff; k++)
							text.push_back(tstr[8*k +: 8]);
					end else if (eff > 1 && r < 40) begin
						// broken occurrence: a prefix of the target only
						cut = $urandom_range(1, eff - 1);
						for (k = 0; k < cut; k++)
							text.push_back(tstr[8*k +: 8]);
					end else if (r < 85) begin
						text.push_back(alpha[$urandom_range(0, 2)]);
					end else begin
						text.push_back(byte_t'($urandom_range(0, 255)));
					end
				end
				for (k = 0; k < text.size(); k++)
					send_word(text[k], k == text.size() - 1);
				phase_words += text.size();
			end
			total += phase_words;
		end
	endtask

	always @(posedge clk) begin : drive_ready
		if (rx_hold_served != rx_hold_requests) begin
			rx_hold_served <= rx_hold_requests;
			rx_hold_left <= RX_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_quiet) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin : check_words
		edit_word_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing expected", m_tdata, 8'h00);
			end else begin
				want = expected_words.pop_front();
				if (m_tdata !== want.out_byte)
					report_mismatch("out_byte", m_tdata, want.out_byte);
				if (m_tuser[0] !== want.has_byte)
					report_mismatch("has_byte", 8'(m_tuser[0]), 8'(want.has_byte));
				if (m_tlast !== want.run_end)
					report_mismatch("run_end", 8'(m_tlast), 8'(want.run_end));
				if (m_tuser[1] !== want.text_done)
					report_mismatch("text_done", 8'(m_tuser[1]), 8'(want.text_done));
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
					(cfg_valid && cfg_ready === 1'b1)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("no word accepted for %0d cycles", STUCK_LIMIT);
				$display("stream_find_replace test failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough_after_reset();
		test_replace();
		test_delete_end_marker();
		test_full_length_strings();
		test_oversized_lengths();
		test_target_change_mid_text();
		test_output_backpressure();
		test_back_to_back();
		test_random_texts();
		wait_drained();
		if (expected_words.size() != 0)
			report_mismatch("words still expected at end", 8'(expected_words.size()), 8'h00);
		$display("sent %0d text words under %0d settings (%0d register writes), checked %0d",
			words_sent, settings_applied, cfg_writes, words_checked);
		$display("covered pass-through, replace, delete, end marker, clamped lengths, %s",
			"mid-text target change, output hold-off and back-to-back streaming");
		if (error_count == 0) begin
			$display("stream_find_replace test passed");
		end else begin
			$display("stream_find_replace test failed");
		end
		$finish;
	end

endmodule
